// File: hw/rtl/script_tokenizer_top_macros.svh
// assertion macros for the script tokenizer checker
// depends on nothing; included by the checker file
`ifndef SCRIPT_TOKENIZER_TOP_MACROS_SVH
`define SCRIPT_TOKENIZER_TOP_MACROS_SVH

// property that must hold in the same cycle
`define STK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// property that must hold in the following cycle
`define STK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// File: hw/rtl/stk_pkg.sv
// shared constants, token kinds and keyword table for the script tokenizer
// depends on nothing
`default_nettype none
package stk_pkg;

    localparam int KEYWORD_MAX_LEN_DEF = 8;
    localparam int LINE_BITS_DEF       = 20;
    localparam int COLUMN_BITS_DEF     = 16;

    localparam int KIND_W = 6;
    localparam int LINE_W = 20;
    localparam int COL_W  = 16;
    localparam int LEN_W  = 16;
    localparam int NUM_KW = 16;

    localparam logic [KIND_W-1:0] K_EOF      = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT    = 6'd1;
    localparam logic [KIND_W-1:0] K_NUMBER   = 6'd2;
    localparam logic [KIND_W-1:0] K_STRING   = 6'd3;
    localparam logic [KIND_W-1:0] K_LPAREN   = 6'd4;
    localparam logic [KIND_W-1:0] K_RPAREN   = 6'd5;
    localparam logic [KIND_W-1:0] K_LBRACE   = 6'd6;
    localparam logic [KIND_W-1:0] K_RBRACE   = 6'd7;
    localparam logic [KIND_W-1:0] K_LBRACK   = 6'd8;
    localparam logic [KIND_W-1:0] K_RBRACK   = 6'd9;
    localparam logic [KIND_W-1:0] K_COMMA    = 6'd10;
    localparam logic [KIND_W-1:0] K_SEMI     = 6'd11;
    localparam logic [KIND_W-1:0] K_COLON    = 6'd12;
    localparam logic [KIND_W-1:0] K_DOT      = 6'd13;
    localparam logic [KIND_W-1:0] K_DOTDOT   = 6'd14;
    localparam logic [KIND_W-1:0] K_ELLIPSIS = 6'd15;
    localparam logic [KIND_W-1:0] K_EQEQ     = 6'd16;
    localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd17;
    localparam logic [KIND_W-1:0] K_NE       = 6'd18;
    localparam logic [KIND_W-1:0] K_LE       = 6'd19;
    localparam logic [KIND_W-1:0] K_LT       = 6'd20;
    localparam logic [KIND_W-1:0] K_GE       = 6'd21;
    localparam logic [KIND_W-1:0] K_GT       = 6'd22;
    localparam logic [KIND_W-1:0] K_PLUS     = 6'd23;
    localparam logic [KIND_W-1:0] K_MINUS    = 6'd24;
    localparam logic [KIND_W-1:0] K_STAR     = 6'd25;
    localparam logic [KIND_W-1:0] K_SLASH    = 6'd26;
    localparam logic [KIND_W-1:0] K_PERCENT  = 6'd27;
    localparam logic [KIND_W-1:0] K_CARET    = 6'd28;
    localparam logic [KIND_W-1:0] K_COMMENT  = 6'd29;
    localparam logic [KIND_W-1:0] K_KEYWORD0 = 6'd30;
    localparam logic [KIND_W-1:0] K_ERROR    = 6'd46;

    localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_tok;

    // keyword text, first character in the low byte
    function automatic logic [63:0] kw_text(input logic [3:0] idx);
        logic [63:0] t;
        unique case (idx)
            4'd0:  t = 64'h6669;
            4'd1:  t = 64'h6573_6c65;
            4'd2:  t = 64'h6669_6573_6c65;
            4'd3:  t = 64'h6e65_6874;
            4'd4:  t = 64'h646e_65;
            4'd5:  t = 64'h65_6c69_6877;
            4'd6:  t = 64'h6f64;
            4'd7:  t = 64'h726f_66;
            4'd8:  t = 64'h6e69;
            4'd9:  t = 64'h6e6f_6974_636e_7566;
            4'd10: t = 64'h6c_6163_6f6c;
            4'd11: t = 64'h6e72_7574_6572;
            4'd12: t = 64'h6b_6165_7262;
            4'd13: t = 64'h6c69_6e;
            4'd14: t = 64'h6575_7274;
            default: t = 64'h65_736c_6166;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] idx);
        logic [3:0] l;
        unique case (idx)
            4'd0, 4'd6, 4'd8:          l = 4'd2;
            4'd4, 4'd7, 4'd13:         l = 4'd3;
            4'd1, 4'd3, 4'd14:         l = 4'd4;
            4'd5, 4'd10, 4'd12, 4'd15: l = 4'd5;
            4'd2, 4'd11:               l = 4'd6;
            default:                   l = 4'd8;
        endcase
        return l;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == 8'h5f;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stk_if.sv
// valid/ready channels for source bytes and tokens
// depends on stk_pkg for field widths
`default_nettype none
interface stk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    logic       end_of_input;
    modport source (output valid, output byte_req, output end_of_input, input ready);
    modport sink   (input valid, input byte_req, input end_of_input, output ready);
endinterface

interface stk_out_if;
    logic                          valid;
    logic                          ready;
    logic [stk_pkg::KIND_W-1:0]    token_kind;
    logic [stk_pkg::LINE_W-1:0]    token_line;
    logic [stk_pkg::COL_W-1:0]     token_column;
    logic [stk_pkg::LEN_W-1:0]     token_length;
    logic                          last;
    modport source (output valid, output token_kind, output token_line, output token_column,
                    output token_length, output last, input ready);
    modport sink   (input valid, input token_kind, input token_line, input token_column,
                    input token_length, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/script_tokenizer_top.sv
// streaming lexer: source bytes in, tokens out through a two-entry result buffer
// depends on stk_pkg and the channel interfaces in stk_if.sv
//
//  channel | dir | interface  | payload
//  i_in    | in  | stk_in_if  | byte_req, end_of_input
//  o_out   | out | stk_out_if | token_kind, token_line, token_column, token_length, last
//
// one byte is accepted per cycle unless the input stalls; its tokens are registered and visible the next cycle
// a byte that yields two tokens holds off the input while both drain
// input stalls while two tokens wait, or while one waits and is not taken
// reset is synchronous; it clears the scanner state and buffer count
`default_nettype none
module script_tokenizer_top #(
    parameter int KEYWORD_MAX_LEN = stk_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int LINE_BITS       = stk_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS     = stk_pkg::COLUMN_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    stk_in_if.sink      i_in,
    stk_out_if.source   o_out
);

    localparam int IW = $clog2(KEYWORD_MAX_LEN);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_COMMENT, M_DOT, M_DOTDOT,
        M_EQ, M_BANG, M_LT, M_GT, M_MINUS
    } t_mode;

    t_mode                      r_mode, n_mode;
    logic [7:0]                 r_kbuf [KEYWORD_MAX_LEN];
    logic                       r_overlong, n_overlong;
    logic [stk_pkg::LEN_W-1:0]  r_len, n_len;
    logic                       r_qsingle, n_qsingle;
    logic                       r_esc, n_esc;
    logic [LINE_BITS-1:0]       r_line, n_line;
    logic [COLUMN_BITS-1:0]     r_col, n_col;
    stk_pkg::t_tok              r_slot [2];
    logic [1:0]                 r_cnt;

    logic [7:0]                 b;
    logic                       eoi, acc, pop;
    logic                       kb_we;
    logic [IW-1:0]              kb_idx;
    logic [stk_pkg::KIND_W-1:0] name_kind, fl_kind, f_kind, s_kind;
    logic [stk_pkg::LEN_W-1:0]  fl_len, f_len, s_len, len_inc;
    logic                       fl_v, f_v, s_v, consumed;
    logic [LINE_BITS-1:0]       adv_line;
    logic [COLUMN_BITS-1:0]     adv_col;
    stk_pkg::t_tok              f_tok, s_tok;

    function automatic stk_pkg::t_tok mk_tok(input logic [stk_pkg::KIND_W-1:0] kind,
                                             input logic [stk_pkg::LEN_W-1:0] len,
                                             input logic [LINE_BITS-1:0] line,
                                             input logic [COLUMN_BITS-1:0] col,
                                             input logic lst);
        stk_pkg::t_tok t;
        logic [32:0]   ca, la, d;
        logic [31:0]   lw;
        ca = 33'(col);
        la = 33'(len);
        d  = ca - la;
        lw = 32'(line);
        t.kind   = kind;
        t.line   = lw[stk_pkg::LINE_W-1:0];
        t.column = (ca > la) ? d[stk_pkg::COL_W-1:0] : '0;
        t.length = len;
        t.last   = lst;
        return t;
    endfunction

    assign b   = i_in.byte_req;
    assign eoi = i_in.end_of_input | (b == 8'd0);
    assign pop = o_out.valid & o_out.ready;
    assign i_in.ready = (r_cnt == 2'd0) | ((r_cnt == 2'd1) & pop);
    assign acc = i_in.valid & i_in.ready;

    assign len_inc  = (r_len == stk_pkg::LEN_MAX) ? r_len : r_len + 1'b1;
    assign adv_line = (b != 8'h0a || &r_line) ? r_line : r_line + 1'b1;
    assign adv_col  = (b == 8'h0a) ? COLUMN_BITS'(1) : ((&r_col) ? r_col : r_col + 1'b1);

    // keyword lookup over the written part of the name buffer
    always_comb begin
        logic hit;
        logic [63:0] t;
        name_kind = stk_pkg::K_IDENT;
        for (int k = stk_pkg::NUM_KW - 1; k >= 0; k--) begin
            t   = stk_pkg::kw_text(4'(k));
            hit = !r_overlong && (r_len == stk_pkg::LEN_W'(stk_pkg::kw_len(4'(k))));
            for (int j = 0; j < 8; j++) begin
                if (j < int'(stk_pkg::kw_len(4'(k))) && r_kbuf[IW'(j)] != t[8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                name_kind = stk_pkg::K_KEYWORD0 + stk_pkg::KIND_W'(k);
            end
        end
    end

    // token that the pending mode gives when closed as it stands
    always_comb begin
        fl_v    = 1'b1;
        fl_kind = stk_pkg::K_ERROR;
        fl_len  = 16'd1;
        unique case (r_mode)
            M_IDENT:   begin fl_kind = name_kind;          fl_len = r_len; end
            M_NUMBER:  begin fl_kind = stk_pkg::K_NUMBER;  fl_len = r_len; end
            M_STRING:  begin fl_kind = stk_pkg::K_STRING;  fl_len = r_len; end
            M_COMMENT: begin fl_kind = stk_pkg::K_COMMENT; fl_len = '0;    end
            M_DOT:     fl_kind = stk_pkg::K_DOT;
            M_DOTDOT:  begin fl_kind = stk_pkg::K_DOTDOT;  fl_len = 16'd2; end
            M_EQ:      fl_kind = stk_pkg::K_ASSIGN;
            M_BANG:    fl_kind = stk_pkg::K_ERROR;
            M_LT:      fl_kind = stk_pkg::K_LT;
            M_GT:      fl_kind = stk_pkg::K_GT;
            M_MINUS:   fl_kind = stk_pkg::K_MINUS;
            default:   fl_v = 1'b0;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_overlong = r_overlong;
        n_len      = r_len;
        n_qsingle  = r_qsingle;
        n_esc      = r_esc;
        n_line     = adv_line;
        n_col      = adv_col;
        kb_we      = 1'b0;
        kb_idx     = r_len[IW-1:0];
        f_v        = 1'b0;
        f_kind     = fl_kind;
        f_len      = fl_len;
        s_v        = 1'b0;
        s_kind     = stk_pkg::K_EOF;
        s_len      = '0;
        consumed   = 1'b0;
        if (eoi) begin
            f_v        = fl_v;
            s_v        = 1'b1;
            n_mode     = M_IDLE;
            n_overlong = 1'b0;
            n_len      = '0;
            n_qsingle  = 1'b0;
            n_esc      = 1'b0;
            n_line     = LINE_BITS'(1);
            n_col      = COLUMN_BITS'(1);
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (stk_pkg::is_name(b)) begin
                        consumed = 1'b1;
                        if (r_len < stk_pkg::LEN_W'(KEYWORD_MAX_LEN)) kb_we = 1'b1;
                        else n_overlong = 1'b1;
                        n_len = len_inc;
                    end
                end
                M_NUMBER: begin
                    if (stk_pkg::is_digit(b) || b == 8'h2e) begin
                        consumed = 1'b1;
                        n_len    = len_inc;
                    end
                end
                M_STRING: begin
                    consumed = 1'b1;
                    if (r_esc) begin
                        n_esc = 1'b0;
                        n_len = len_inc;
                    end else if (b == (r_qsingle ? 8'h27 : 8'h22)) begin
                        s_v    = 1'b1;
                        s_kind = stk_pkg::K_STRING;
                        s_len  = r_len;
                        n_mode = M_IDLE;
                    end else begin
                        n_esc = (b == 8'h5c);
                        n_len = len_inc;
                    end
                end
                M_COMMENT: consumed = (b != 8'h0a);
                M_DOT: begin
                    if (b == 8'h2e) begin
                        consumed = 1'b1;
                        n_mode   = M_DOTDOT;
                    end
                end
                M_MINUS: begin
                    if (b == 8'h2d) begin
                        consumed = 1'b1;
                        n_mode   = M_COMMENT;
                    end
                end
                M_DOTDOT, M_EQ, M_BANG, M_LT, M_GT: begin
                    if (b == ((r_mode == M_DOTDOT) ? 8'h2e : 8'h3d)) begin
                        consumed = 1'b1;
                        s_v      = 1'b1;
                        s_len    = (r_mode == M_DOTDOT) ? 16'd3 : 16'd2;
                        n_mode   = M_IDLE;
                        unique case (r_mode)
                            M_DOTDOT: s_kind = stk_pkg::K_ELLIPSIS;
                            M_EQ:     s_kind = stk_pkg::K_EQEQ;
                            M_BANG:   s_kind = stk_pkg::K_NE;
                            M_LT:     s_kind = stk_pkg::K_LE;
                            default:  s_kind = stk_pkg::K_GE;
                        endcase
                    end
                end
                default: ;
            endcase
            // byte not taken by the pending token: close it, scan from idle
            if (!consumed) begin
                f_v    = fl_v;
                n_mode = M_IDLE;
                if (stk_pkg::is_space(b)) begin
                    n_mode = M_IDLE;
                end else if (stk_pkg::is_alpha(b) || b == 8'h5f) begin
                    kb_we      = 1'b1;
                    kb_idx     = '0;
                    n_len      = 16'd1;
                    n_overlong = 1'b0;
                    n_mode     = M_IDENT;
                end else if (stk_pkg::is_digit(b)) begin
                    n_len  = 16'd1;
                    n_mode = M_NUMBER;
                end else begin
                    s_len = 16'd1;
                    unique case (b)
                        8'h22, 8'h27: begin
                            n_qsingle = (b == 8'h27);
                            n_esc     = 1'b0;
                            n_len     = '0;
                            n_mode    = M_STRING;
                        end
                        8'h2e: n_mode = M_DOT;
                        8'h3d: n_mode = M_EQ;
                        8'h21: n_mode = M_BANG;
                        8'h3c: n_mode = M_LT;
                        8'h3e: n_mode = M_GT;
                        8'h2d: n_mode = M_MINUS;
                        8'h28: begin s_v = 1'b1; s_kind = stk_pkg::K_LPAREN;  end
                        8'h29: begin s_v = 1'b1; s_kind = stk_pkg::K_RPAREN;  end
                        8'h7b: begin s_v = 1'b1; s_kind = stk_pkg::K_LBRACE;  end
                        8'h7d: begin s_v = 1'b1; s_kind = stk_pkg::K_RBRACE;  end
                        8'h5b: begin s_v = 1'b1; s_kind = stk_pkg::K_LBRACK;  end
                        8'h5d: begin s_v = 1'b1; s_kind = stk_pkg::K_RBRACK;  end
                        8'h2c: begin s_v = 1'b1; s_kind = stk_pkg::K_COMMA;   end
                        8'h3b: begin s_v = 1'b1; s_kind = stk_pkg::K_SEMI;    end
                        8'h3a: begin s_v = 1'b1; s_kind = stk_pkg::K_COLON;   end
                        8'h2b: begin s_v = 1'b1; s_kind = stk_pkg::K_PLUS;    end
                        8'h2a: begin s_v = 1'b1; s_kind = stk_pkg::K_STAR;    end
                        8'h2f: begin s_v = 1'b1; s_kind = stk_pkg::K_SLASH;   end
                        8'h25: begin s_v = 1'b1; s_kind = stk_pkg::K_PERCENT; end
                        8'h5e: begin s_v = 1'b1; s_kind = stk_pkg::K_CARET;   end
                        default: begin s_v = 1'b1; s_kind = stk_pkg::K_ERROR; end
                    endcase
                end
            end
        end
    end

    // closing token sees the old position, the second one the advanced position (the old one at end of input)
    assign f_tok = mk_tok(f_kind, f_len, r_line, r_col, !s_v);
    assign s_tok = mk_tok(s_kind, s_len, eoi ? r_line : adv_line, eoi ? r_col : adv_col, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_overlong <= 1'b0;
            r_len      <= '0;
            r_qsingle  <= 1'b0;
            r_esc      <= 1'b0;
            r_line     <= LINE_BITS'(1);
            r_col      <= COLUMN_BITS'(1);
            r_cnt      <= 2'd0;
        end else begin
            if (acc) begin
                r_mode     <= n_mode;
                r_overlong <= n_overlong;
                r_len      <= n_len;
                r_qsingle  <= n_qsingle;
                r_esc      <= n_esc;
                r_line     <= n_line;
                r_col      <= n_col;
                r_cnt      <= 2'(f_v) + 2'(s_v);
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (kb_we) r_kbuf[kb_idx] <= b;
            r_slot[0] <= f_v ? f_tok : s_tok;
            r_slot[1] <= s_tok;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.token_kind   = r_slot[0].kind;
    assign o_out.token_line   = r_slot[0].line;
    assign o_out.token_column = r_slot[0].column;
    assign o_out.token_length = r_slot[0].length;
    assign o_out.last         = r_slot[0].last;

endmodule
`default_nettype wire

// File: hw/rtl/stk_checker.sv
// port-level checks for the script tokenizer, bound to the top level
// depends on stk_pkg and script_tokenizer_top_macros.svh
`default_nettype none
`include "script_tokenizer_top_macros.svh"
module stk_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_ready,
    input wire                             i_out_valid,
    input wire                             i_out_ready,
    input wire [stk_pkg::KIND_W-1:0]       i_kind,
    input wire [stk_pkg::LEN_W-1:0]        i_length,
    input wire                             i_last
);

    // end-of-file always closes the tokens of its byte and has no length
    `STK_ASSERT_NOW(a_eof_last, i_clk, i_rst_n, i_out_valid && i_kind == stk_pkg::K_EOF, i_last)
    `STK_ASSERT_NOW(a_eof_len, i_clk, i_rst_n, i_out_valid && i_kind == stk_pkg::K_EOF, i_length == '0)
    // empty result buffer never holds off the source
    `STK_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    // a stalled token stays put
    `STK_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind))

endmodule

bind script_tokenizer_top stk_checker u_stk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.token_kind),
    .i_length    (o_out.token_length),
    .i_last      (o_out.last)
);
`default_nettype wire

// File: tb/stk_token_checker.sv
// token checker: watches both channels, predicts tokens from accepted bytes and compares
// depends on stk_pkg and the channel interfaces in stk_if.sv
`default_nettype none
module stk_token_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    stk_in_if          in_ch,
    stk_out_if         out_ch,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        SC_IDLE, SC_IDENT, SC_NUMBER, SC_STRING, SC_COMMENT, SC_DOT, SC_DOTDOT,
        SC_EQ, SC_BANG, SC_LT, SC_GT, SC_MINUS
    } t_scan;

    localparam int NAME_MAX = 8;
    localparam int LINE_SAT = (1 << 20) - 1;
    localparam int COL_SAT  = (1 << 16) - 1;
    localparam int LEN_SAT  = 65535;

    string reserved_words [16] = '{"if", "else", "elseif", "then", "end", "while", "do",
        "for", "in", "function", "local", "return", "break", "nil", "true", "false"};

    stk_pkg::t_tok token_queue [$];
    t_scan        scan;
    logic [7:0]   name_buf [NAME_MAX];
    bit           name_long;
    int           lex_len;
    bit           single_quote;
    bit           escaped;
    int           cur_line;
    int           cur_col;

    assign o_pending = token_queue.size();

    function automatic bit alpha_c(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic bit digit_c(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function void clear_scanner();
        scan = SC_IDLE;
        foreach (name_buf[i]) name_buf[i] = 8'h00;
        name_long = 0;
        lex_len = 0;
        single_quote = 0;
        escaped = 0;
        cur_line = 1;
        cur_col = 1;
    endfunction

    function void step_pos(logic [7:0] b);
        if (b == 8'h0a) begin
            if (cur_line < LINE_SAT) cur_line++;
            cur_col = 1;
        end else if (cur_col < COL_SAT) begin
            cur_col++;
        end
    endfunction

    function void lengthen();
        if (lex_len < LEN_SAT) lex_len++;
    endfunction

    function void push_token(logic [stk_pkg::KIND_W-1:0] kind, int len);
        stk_pkg::t_tok t;
        int c;
        c = cur_col > len ? cur_col - len : 0;
        t.kind = kind;
        t.line = cur_line[stk_pkg::LINE_W-1:0];
        t.column = c[stk_pkg::COL_W-1:0];
        t.length = len[stk_pkg::LEN_W-1:0];
        t.last = 1'b0;
        token_queue.push_back(t);
    endfunction

    function logic [stk_pkg::KIND_W-1:0] name_kind();
        bit hit;
        if (name_long || lex_len > NAME_MAX) return stk_pkg::K_IDENT;
        for (int i = 0; i < 16; i++) begin
            if (reserved_words[i].len() == lex_len) begin
                hit = 1;
                for (int j = 0; j < lex_len; j++)
                    if (name_buf[j] != reserved_words[i][j]) hit = 0;
                if (hit) return stk_pkg::K_KEYWORD0 + i[stk_pkg::KIND_W-1:0];
            end
        end
        return stk_pkg::K_IDENT;
    endfunction

    // emit whatever is pending as it stands
    function void close_pending();
        case (scan)
            SC_IDENT:   push_token(name_kind(), lex_len);
            SC_NUMBER:  push_token(stk_pkg::K_NUMBER, lex_len);
            SC_STRING:  push_token(stk_pkg::K_STRING, lex_len);
            SC_COMMENT: push_token(stk_pkg::K_COMMENT, 0);
            SC_DOT:     push_token(stk_pkg::K_DOT, 1);
            SC_DOTDOT:  push_token(stk_pkg::K_DOTDOT, 2);
            SC_EQ:      push_token(stk_pkg::K_ASSIGN, 1);
            SC_BANG:    push_token(stk_pkg::K_ERROR, 1);
            SC_LT:      push_token(stk_pkg::K_LT, 1);
            SC_GT:      push_token(stk_pkg::K_GT, 1);
            SC_MINUS:   push_token(stk_pkg::K_MINUS, 1);
            default: ;
        endcase
        scan = SC_IDLE;
    endfunction

    // true when the pending token swallows the byte
    function bit absorb(logic [7:0] b);
        logic [7:0] want;
        logic [stk_pkg::KIND_W-1:0] k;
        case (scan)
            SC_IDLE: return 0;
            SC_IDENT: begin
                if (alpha_c(b) || digit_c(b) || b == "_") begin
                    if (lex_len < NAME_MAX) name_buf[lex_len] = b;
                    else name_long = 1;
                    lengthen();
                    step_pos(b);
                    return 1;
                end
            end
            SC_NUMBER: begin
                if (digit_c(b) || b == ".") begin
                    lengthen();
                    step_pos(b);
                    return 1;
                end
            end
            SC_STRING: begin
                step_pos(b);
                if (escaped) begin
                    escaped = 0;
                    lengthen();
                end else if (b == (single_quote ? 8'h27 : 8'h22)) begin
                    push_token(stk_pkg::K_STRING, lex_len);
                    scan = SC_IDLE;
                end else begin
                    if (b == 8'h5c) escaped = 1;
                    lengthen();
                end
                return 1;
            end
            SC_COMMENT: begin
                if (b != 8'h0a) begin
                    step_pos(b);
                    return 1;
                end
            end
            SC_DOT: begin
                if (b == ".") begin
                    step_pos(b);
                    scan = SC_DOTDOT;
                    return 1;
                end
            end
            SC_MINUS: begin
                if (b == "-") begin
                    step_pos(b);
                    scan = SC_COMMENT;
                    return 1;
                end
            end
            default: begin
                want = (scan == SC_DOTDOT) ? "." : "=";
                case (scan)
                    SC_DOTDOT: k = stk_pkg::K_ELLIPSIS;
                    SC_EQ:     k = stk_pkg::K_EQEQ;
                    SC_BANG:   k = stk_pkg::K_NE;
                    SC_LT:     k = stk_pkg::K_LE;
                    default:   k = stk_pkg::K_GE;
                endcase
                if (b == want) begin
                    step_pos(b);
                    push_token(k, scan == SC_DOTDOT ? 3 : 2);
                    scan = SC_IDLE;
                    return 1;
                end
            end
        endcase
        close_pending();
        return 0;
    endfunction

    function void start_token(logic [7:0] b);
        logic [stk_pkg::KIND_W-1:0] k;
        if (b == 8'h20 || (b >= 8'd9 && b <= 8'd13)) begin
            step_pos(b);
            return;
        end
        if (alpha_c(b) || b == "_") begin
            name_buf[0] = b;
            lex_len = 1;
            name_long = 0;
            scan = SC_IDENT;
            step_pos(b);
            return;
        end
        if (digit_c(b)) begin
            lex_len = 1;
            scan = SC_NUMBER;
            step_pos(b);
            return;
        end
        step_pos(b);
        case (b)
            8'h22, 8'h27: begin
                single_quote = (b == 8'h27);
                escaped = 0;
                lex_len = 0;
                scan = SC_STRING;
                return;
            end
            ".": begin scan = SC_DOT; return; end
            "=": begin scan = SC_EQ; return; end
            "!": begin scan = SC_BANG; return; end
            "<": begin scan = SC_LT; return; end
            ">": begin scan = SC_GT; return; end
            "-": begin scan = SC_MINUS; return; end
            "(": k = stk_pkg::K_LPAREN;
            ")": k = stk_pkg::K_RPAREN;
            "{": k = stk_pkg::K_LBRACE;
            "}": k = stk_pkg::K_RBRACE;
            "[": k = stk_pkg::K_LBRACK;
            "]": k = stk_pkg::K_RBRACK;
            ",": k = stk_pkg::K_COMMA;
            ";": k = stk_pkg::K_SEMI;
            ":": k = stk_pkg::K_COLON;
            "+": k = stk_pkg::K_PLUS;
            "*": k = stk_pkg::K_STAR;
            "/": k = stk_pkg::K_SLASH;
            "%": k = stk_pkg::K_PERCENT;
            "^": k = stk_pkg::K_CARET;
            default: k = stk_pkg::K_ERROR;
        endcase
        push_token(k, 1);
    endfunction

    function void predict_tokens(logic [7:0] b, logic eoi);
        int n_prior;
        n_prior = token_queue.size();
        if (eoi || b == 8'h00) begin
            close_pending();
            push_token(stk_pkg::K_EOF, 0);
            clear_scanner();
        end else if (!absorb(b)) begin
            start_token(b);
        end
        if (token_queue.size() > n_prior) token_queue[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        stk_pkg::t_tok exp_t;
        stk_pkg::t_tok got;
        if (!i_rst_n) begin
            clear_scanner();
            token_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.token_kind, out_ch.token_line, out_ch.token_column,
                        out_ch.token_length, out_ch.last};
                if (token_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected token: kind %0d line %0d col %0d len %0d last %0d",
                                 got.kind, got.line, got.column, got.length, got.last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_t = token_queue.pop_front();
                    if (got !== exp_t) begin
                        if (o_fail_count < 10)
                            $display("token mismatch: exp kind %0d line %0d col %0d len %0d last %0d, got kind %0d line %0d col %0d len %0d last %0d",
                                     exp_t.kind, exp_t.line, exp_t.column, exp_t.length,
                                     exp_t.last, got.kind, got.line, got.column, got.length,
                                     got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_tokens(in_ch.byte_req, in_ch.end_of_input);
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_script_tokenizer_top.sv
// top of the tokenizer testbench: clock, reset, byte stimulus and verdict
// depends on stk_pkg, stk_if.sv, the checker module and script_tokenizer_top
`default_nettype none
module tb_script_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   quiet = 0;
    int   items_sent = 0;
    int   cyc = 0;
    int   stall_left = 0;

    stk_in_if  in_ch ();
    stk_out_if out_ch ();

    script_tokenizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    stk_token_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    string reserved_words [16] = '{"if", "else", "elseif", "then", "end", "while", "do",
        "for", "in", "function", "local", "return", "break", "nil", "true", "false"};
    string operators [24] = '{"(", ")", "{", "}", "[", "]", ",", ";", ":", ".", "..", "...",
        "==", "=", "!=", "!", "<=", "<", ">=", ">", "+", "*", "/", "%"};

    always #2 i_clk = ~i_clk;

    // token receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (cyc == 300) begin
            stall_left <= 200;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 10);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic put_word(input logic [7:0] b, input logic eoi = 1'b0);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.byte_req <= b;
        in_ch.end_of_input <= eoi;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_word(s[i]);
    endtask

    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 3))
            0: return 8'("0" + $urandom_range(0, 9));
            1: return "_";
            2: return 8'("A" + $urandom_range(0, 25));
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic put_random_token();
        int n;
        logic [7:0] q;
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                put_text(reserved_words[$urandom_range(0, 15)]);
                if ($urandom_range(0, 3) == 0) put_word(name_char());
            end
            3, 4: begin
                put_word($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : "_");
                n = $urandom_range(0, 11);
                repeat (n) put_word(name_char());
            end
            5, 6: begin
                put_word(8'("0" + $urandom_range(0, 9)));
                repeat ($urandom_range(0, 5))
                    put_word($urandom_range(0, 3) == 0 ? "." : 8'("0" + $urandom_range(0, 9)));
            end
            7, 8: begin
                q = $urandom_range(0, 1) ? 8'h27 : 8'h22;
                put_word(q);
                repeat ($urandom_range(0, 8)) begin
                    case ($urandom_range(0, 5))
                        0: put_word(8'h5c);
                        1: put_word($urandom_range(0, 1) ? 8'h22 : 8'h27);
                        2: put_word(8'h0a);
                        default: put_word(8'($urandom_range(32, 126)));
                    endcase
                end
                if ($urandom_range(0, 7) != 0) put_word(q);
            end
            9: begin
                put_text("--");
                repeat ($urandom_range(0, 8)) put_word(8'($urandom_range(1, 255)));
                put_word(8'h0a);
            end
            10, 11, 12, 13: put_text(operators[$urandom_range(0, 23)]);
            14: put_text($urandom_range(0, 1) ? "-" : "^");
            15, 16: put_word($urandom_range(0, 2) == 0 ? 8'h0a : 8'h20);
            17: put_word(8'($urandom_range(1, 255)));
            18: put_word(8'(8'h09 + $urandom_range(0, 4)));
            default: begin
                if ($urandom_range(0, 4) == 0)
                    put_word($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)), 1'b1);
                else
                    put_word(8'h20);
            end
        endcase
    endtask

    initial begin
        #(4 * 900000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.byte_req = 8'h00;
        in_ch.end_of_input = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keywords, long names, operators, lone bang, unknown bytes
        put_text("elseif functions x9 1.2.. 'a\\'b' \"c");
        put_word(8'h5c);
        put_word(8'h00);
        put_text("!x !=<=>=...&");
        put_word(8'hff);
        put_word(8'h80, 1'b1);
        put_text("-- z\n-");
        put_word(8'h00);

        // a name past the keyword buffer length is never a keyword
        put_text("functionfunctionx");
        put_word(" ");
        put_word(8'h00, 1'b1);

        while (items_sent < 650) put_random_token();
        // drain fully before carrying on
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        while (items_sent < 1050) put_random_token();
        quiet = 1;
        while (items_sent < 1250) put_random_token();
        put_word(8'h00, 1'b1);
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
